@@ hdl/assert_macros.svh @@
// Assertion macros shared by the PI position step RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pias_pkg.sv @@
// Types and constants of the PI position step block.
`default_nettype none

package pias_pkg;

  localparam int GAIN_W = 16;
  localparam int STEP_W = 15;
  localparam int ZONE_W = 16;
  localparam int WIND_W = 16;
  localparam int INT_W  = 18;

  localparam int RST_PROP_GAIN  = 4915;
  localparam int RST_INTEG_GAIN = 1434;
  localparam int RST_STEP_LIMIT = 10000;
  localparam int RST_POS_LOW    = -16770;
  localparam int RST_POS_HIGH   = 16770;
  localparam int RST_ZONE_WIDTH = 2236;
  localparam int RST_WINDUP     = 1677;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } err_sign_t;

  typedef enum logic [2:0] {
    REG_REQ_POS      = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_STEP_LIMIT   = 3'd3,
    REG_POS_LOW      = 3'd4,
    REG_POS_HIGH     = 3'd5,
    REG_ZONE_WIDTH   = 3'd6,
    REG_WINDUP_LIMIT = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ hdl/pias_if.sv @@
// Stream interfaces for measured positions and target results.
`default_nettype none

interface pias_meas_if #(parameter int POS_WIDTH = 16) ();
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] measured_position;

  modport source (output valid, output measured_position, input ready);
  modport sink (input valid, input measured_position, output ready);
endinterface

interface pias_target_if #(parameter int POS_WIDTH = 16) ();
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] next_target;
  logic                        move_limited;

  modport source (output valid, output next_target, output move_limited, input ready);
  modport sink (input valid, input next_target, input move_limited, output ready);
endinterface

`default_nettype wire

@@ hdl/pi_axis_position_step.sv @@
// PI position step: one measured position in, one clamped target position out.
//
// Usage:
//   in_ch carries measured_position beats, out_ch carries next_target and
//   move_limited beats; both use valid/ready and a beat moves when both are high.
//   cfg_we/cfg_index/cfg_data write the eight control registers (setpoint, gains,
//   step limit, position range, integration zone, windup clamp); write them only
//   while no beat is in flight.
// Timing:
//   Four register stages: input, error/integral, gain products, result.
//   A measurement moves through the error/integral, product and result stages.
//   One measurement per cycle is accepted unless stalled; the integral update
//   is one add and clamp in the error stage, so beats chain without gaps.
// Reset:
//   rst_n (synchronous, active low) clears the integral, the stored error sign
//   and all pipeline valids, and loads the register defaults.
// Stall:
//   When out_ch.ready is low with a result waiting, the whole pipeline holds
//   and in_ch.ready drops; up to four beats sit in flight meanwhile.
`default_nettype none

module pi_axis_position_step #(
  parameter int POS_WIDTH = 16,
  parameter int GAIN_FRAC_BITS = 12,
  localparam int CFG_W = (POS_WIDTH > 16) ? POS_WIDTH : 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  pias_meas_if.sink             in_ch,
  pias_target_if.source         out_ch,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  import pias_pkg::*;

  `include "assert_macros.svh"

  localparam int ERR_W = POS_WIDTH + 1;
  localparam int P_W   = ERR_W + GAIN_W + 1;
  localparam int I_W   = INT_W + GAIN_W + 1;

  // Control registers
  logic signed [POS_WIDTH-1:0] req_pos_r, pos_low_r, pos_high_r;
  logic        [GAIN_W-1:0]    prop_gain_r, integ_gain_r;
  logic        [STEP_W-1:0]    step_limit_r;
  logic        [ZONE_W-1:0]    zone_width_r;
  logic        [WIND_W-1:0]    windup_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_pos_r    <= '0;
      prop_gain_r  <= GAIN_W'(RST_PROP_GAIN);
      integ_gain_r <= GAIN_W'(RST_INTEG_GAIN);
      step_limit_r <= STEP_W'(RST_STEP_LIMIT);
      pos_low_r    <= POS_WIDTH'(RST_POS_LOW);
      pos_high_r   <= POS_WIDTH'(RST_POS_HIGH);
      zone_width_r <= ZONE_W'(RST_ZONE_WIDTH);
      windup_r     <= WIND_W'(RST_WINDUP);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REQ_POS:      req_pos_r    <= cfg_data[POS_WIDTH-1:0];
        REG_PROP_GAIN:    prop_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain_r <= cfg_data[GAIN_W-1:0];
        REG_STEP_LIMIT:   step_limit_r <= cfg_data[STEP_W-1:0];
        REG_POS_LOW:      pos_low_r    <= cfg_data[POS_WIDTH-1:0];
        REG_POS_HIGH:     pos_high_r   <= cfg_data[POS_WIDTH-1:0];
        REG_ZONE_WIDTH:   zone_width_r <= cfg_data[ZONE_W-1:0];
        REG_WINDUP_LIMIT: windup_r     <= cfg_data[WIND_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline
  logic                        adv, take;
  logic                        a_valid_r, b_valid_r, c_valid_r, out_valid_r;
  logic signed [POS_WIDTH-1:0] a_meas_r, b_meas_r, c_meas_r;
  logic signed [ERR_W-1:0]     b_err_r, err;
  logic signed [INT_W-1:0]     b_integ_r, integral;
  logic signed [P_W-1:0]       c_pterm_r, pterm;
  logic signed [I_W-1:0]       c_iterm_r, iterm;
  logic signed [POS_WIDTH-1:0] out_target_r, target;
  logic                        out_limited_r, limited;

  // Advance everything whenever the result slot is free or being taken.
  assign adv         = !out_valid_r || out_ch.ready;
  assign take        = adv && a_valid_r;
  assign in_ch.ready = adv;

  pias_integ #(.POS_WIDTH(POS_WIDTH)) u_integ (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .measured     (a_meas_r),
    .requested    (req_pos_r),
    .zone_width   (zone_width_r),
    .windup_limit (windup_r),
    .err          (err),
    .integral     (integral)
  );

  assign pterm = P_W'($signed({1'b0, prop_gain_r})) * P_W'(b_err_r);
  assign iterm = I_W'($signed({1'b0, integ_gain_r})) * I_W'(b_integ_r);

  pias_shape #(.POS_WIDTH(POS_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_shape (
    .pterm      (c_pterm_r),
    .iterm      (c_iterm_r),
    .measured   (c_meas_r),
    .step_limit (step_limit_r),
    .pos_low    (pos_low_r),
    .pos_high   (pos_high_r),
    .target     (target),
    .limited    (limited)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_ch.valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_meas_r      <= in_ch.measured_position;
      b_meas_r      <= a_meas_r;
      b_err_r       <= err;
      b_integ_r     <= integral;
      c_meas_r      <= b_meas_r;
      c_pterm_r     <= pterm;
      c_iterm_r     <= iterm;
      out_target_r  <= target;
      out_limited_r <= limited;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.next_target  = out_target_r;
  assign out_ch.move_limited = out_limited_r;

  `ASSERT_RST(a_rst_clear, !rst_n |=> !a_valid_r && !b_valid_r && !c_valid_r && !out_valid_r, "pipeline valid after reset")
  `ASSERT_CLK(a_out_from_c, $rose(out_valid_r) |-> $past(c_valid_r), "result without a product stage beat")
  `ASSERT_CLK(a_drain, out_valid_r && out_ch.ready && !c_valid_r |=> !out_valid_r, "result repeated after it was taken")

endmodule

`default_nettype wire

@@ hdl/pias_integ.sv @@
// Error formation and anti-windup integral state of the PI position step.
`default_nettype none

module pias_integ #(
  parameter int POS_WIDTH = 16,
  localparam int ERR_W = POS_WIDTH + 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               take,
  input  wire logic signed [POS_WIDTH-1:0]        measured,
  input  wire logic signed [POS_WIDTH-1:0]        requested,
  input  wire logic        [pias_pkg::ZONE_W-1:0] zone_width,
  input  wire logic        [pias_pkg::WIND_W-1:0] windup_limit,
  output logic signed      [ERR_W-1:0]            err,
  output logic signed      [pias_pkg::INT_W-1:0]  integral
);
  import pias_pkg::*;

  `include "assert_macros.svh"

  localparam int CMP_W = (ERR_W > ZONE_W + 1) ? ERR_W : ZONE_W + 1;
  localparam int SUM_W = ((ERR_W > INT_W) ? ERR_W : INT_W) + 1;

  logic signed [INT_W-1:0] integ_r, integ_nxt;
  err_sign_t               sign_r, sign_nxt;

  logic signed [ERR_W-1:0] err_w;
  logic        [ERR_W-1:0] mag;
  logic                    in_zone;
  logic                    flip;
  logic signed [SUM_W-1:0] base, acc, lim_s, clamped;

  always_comb begin
    err_w   = {requested[POS_WIDTH-1], requested} - {measured[POS_WIDTH-1], measured};
    mag     = err_w[ERR_W-1] ? ERR_W'(-err_w) : err_w;
    in_zone = CMP_W'(mag) <= CMP_W'(zone_width);
    // Drop the integral when the error changes sign.
    flip    = (err_w > 0 && sign_r == SIGN_NEG) || (err_w < 0 && sign_r == SIGN_POS);
    base    = flip ? '0 : SUM_W'(integ_r);
    acc     = base + SUM_W'(err_w);
    lim_s   = SUM_W'($signed({1'b0, windup_limit}));
    if (acc > lim_s) begin
      clamped = lim_s;
    end else if (acc < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = acc;
    end
    integ_nxt = in_zone ? INT_W'(clamped) : '0;
    if (err_w > 0) begin
      sign_nxt = SIGN_POS;
    end else if (err_w < 0) begin
      sign_nxt = SIGN_NEG;
    end else begin
      sign_nxt = SIGN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      sign_r  <= SIGN_NONE;
    end else if (take) begin
      integ_r <= integ_nxt;
      sign_r  <= sign_nxt;
    end
  end

  assign err      = err_w;
  assign integral = integ_nxt;

  `ASSERT_RST(a_state_reset, !rst_n |=> integ_r == '0 && sign_r == SIGN_NONE, "state not cleared by reset")
  `ASSERT_CLK(a_zero_err_sign, take && err_w == '0 |=> sign_r == SIGN_NONE, "zero error kept a sign")
  `ASSERT_CLK(a_zone_clear, take && !in_zone |=> integ_r == '0, "integral kept outside the zone")

endmodule

`default_nettype wire

@@ hdl/pias_shape.sv @@
// Move rounding, step limiting and position range clamp of the PI position step.
`default_nettype none

module pias_shape #(
  parameter int POS_WIDTH = 16,
  parameter int GAIN_FRAC_BITS = 12,
  localparam int P_W = POS_WIDTH + 1 + pias_pkg::GAIN_W + 1,
  localparam int I_W = pias_pkg::INT_W + pias_pkg::GAIN_W + 1
) (
  input  wire logic signed [P_W-1:0]              pterm,
  input  wire logic signed [I_W-1:0]              iterm,
  input  wire logic signed [POS_WIDTH-1:0]        measured,
  input  wire logic        [pias_pkg::STEP_W-1:0] step_limit,
  input  wire logic signed [POS_WIDTH-1:0]        pos_low,
  input  wire logic signed [POS_WIDTH-1:0]        pos_high,
  output logic signed      [POS_WIDTH-1:0]        target,
  output logic                                    limited
);
  import pias_pkg::*;

  localparam int EX_W = ((P_W > I_W) ? P_W : I_W) + 1;
  localparam int MV_W = STEP_W + 2;
  localparam int TW   = ((POS_WIDTH > MV_W) ? POS_WIDTH : MV_W) + 1;
  localparam logic [GAIN_FRAC_BITS-1:0] HALF = {1'b1, {(GAIN_FRAC_BITS-1){1'b0}}};

  logic signed [EX_W-1:0]           exact, lsc, q, rounded;
  logic        [GAIN_FRAC_BITS-1:0] rbits;
  logic                             round_up, over, under;
  logic signed [MV_W-1:0]           step_s, move;
  logic signed [TW-1:0]             sum, lo_s, hi_s;

  always_comb begin
    exact    = EX_W'(pterm) + EX_W'(iterm);
    lsc      = EX_W'($signed({1'b0, step_limit, {GAIN_FRAC_BITS{1'b0}}}));
    over     = exact > lsc;
    under    = exact < -lsc;
    // Floor, then round half to even on the dropped fraction.
    q        = exact >>> GAIN_FRAC_BITS;
    rbits    = exact[GAIN_FRAC_BITS-1:0];
    round_up = (rbits > HALF) || (rbits == HALF && q[0]);
    rounded  = q + $signed({{(EX_W-1){1'b0}}, round_up});
    step_s   = $signed({2'b00, step_limit});
    if (over) begin
      move = step_s;
    end else if (under) begin
      move = -step_s;
    end else begin
      move = MV_W'(rounded);
    end
    limited = over || under;
    sum  = TW'(measured) + TW'(move);
    lo_s = TW'(pos_low);
    hi_s = TW'(pos_high);
    if (sum > hi_s) begin
      target = pos_high;
    end else if (sum < lo_s) begin
      target = pos_low;
    end else begin
      target = POS_WIDTH'(sum);
    end
  end

endmodule

`default_nettype wire
